### hdl/nibcpu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the nibble CPU instruction step block.
// Used by nibcpu_regfile and nibble_cpu_instruction_step; no dependencies.
package nibcpu_pkg;

   // Index registers are held as eight pairs: [7:4] even register, [3:0] odd register
   localparam int NUM_PAIRS = 8;
   localparam int PAIR_AW   = 3;

   // Opcode nibble (high nibble of the instruction byte)
   localparam logic [3:0] OP_FIM_SRC = 4'h2;
   localparam logic [3:0] OP_FIN     = 4'h3;
   localparam logic [3:0] OP_JUN     = 4'h4;
   localparam logic [3:0] OP_INC     = 4'h6;
   localparam logic [3:0] OP_ISZ     = 4'h7;
   localparam logic [3:0] OP_ADD     = 4'h8;
   localparam logic [3:0] OP_SUB     = 4'h9;
   localparam logic [3:0] OP_LD      = 4'hA;
   localparam logic [3:0] OP_XCH     = 4'hB;
   localparam logic [3:0] OP_LDM     = 4'hD;
   localparam logic [3:0] OP_IO      = 4'hE;
   localparam logic [3:0] OP_ACC     = 4'hF;

   // Operand codes within the accumulator and I/O groups
   localparam logic [3:0] OPA_CLB = 4'h0;
   localparam logic [3:0] OPA_IAC = 4'h2;
   localparam logic [3:0] OPA_KBP = 4'hC;
   localparam logic [3:0] OPA_WRM = 4'h0;
   localparam logic [1:0] OPA_WRN_GROUP = 2'b01;

   // Register pair write port
   typedef struct packed {
      logic               en;
      logic [PAIR_AW-1:0] addr;
      logic [7:0]         data;
   } rf_wr_type;

endpackage

### hdl/nibble_cpu_instruction_step.sv
`timescale 1ns / 1ps
// Top level of the nibble CPU instruction step block.
// Instantiates nibcpu_regfile and nibcpu_store; uses nibcpu_pkg.

// Each input transfer carries one instruction (opcode byte and the following byte) and yields
// one result transfer with the next PC, accumulator, carry and halt flag. The register pair
// is read from the register file as the item is taken and the instruction executes in the
// next cycle unless the result port stalls, so a new instruction is taken every cycle while
// rsp_tready keeps up; FIN also waits for a read of the data store. After reset a clearing
// sweep zeroes the data store and the register file, one entry per cycle, over all STORE_DEPTH
// entries (512 by default); req_tready is low during the sweep. Once KBP has halted the
// machine, further instructions are taken and answered with the unchanged state.
module nibble_cpu_instruction_step #(
   parameter int STORE_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] first_byte, [15:8] second_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [11:0] next_pc, [15:12] accumulator,
                                    // [16] carry_flag, [17] halted, [23:18] zero
);

   localparam int AW = $clog2(STORE_DEPTH);

   // clearing sweep
   logic          clearing_ff;
   logic [AW-1:0] clr_cnt_ff;

   // execute stage
   logic       s1_valid_ff;
   logic [7:0] s1_b0_ff;
   logic [7:0] s1_b1_ff;
   logic       fin_wait_ff;

   // architectural state
   logic [3:0]  acc_ff,   acc_in;
   logic        carry_ff, carry_in;
   logic [11:0] pc_ff,    pc_in;
   logic [3:0]  chip_ff,  chip_in;
   logic [3:0]  nib_ff,   nib_in;
   logic        halt_ff,  halt_in;

   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   logic accept;
   logic out_free;
   logic is_fin;
   logic fin_issue;
   logic exec_fire;

   logic [7:0] rf_rd_data;
   logic [nibcpu_pkg::PAIR_AW-1:0] rf_rd_addr;
   nibcpu_pkg::rf_wr_type rf_wr;

   logic          st_wr_en;
   logic [AW-1:0] st_wr_addr;
   logic [3:0]    st_wr_data;
   logic [3:0]    st_rd_data;

   // execute datapath
   logic [3:0]  opr, opa;
   logic [3:0]  reg_val;
   logic [4:0]  sum5;
   logic [4:0]  sub_t;
   logic [3:0]  reg_inc;
   logic [11:0] pc_inc1, pc_inc2;
   logic [8:0]  sel20;
   logic [8:0]  st_addr9;
   logic        ex_rf_we;
   logic [7:0]  ex_rf_data;
   logic        ex_st_we;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign is_fin    = (s1_b0_ff[7:4] == nibcpu_pkg::OP_FIN) && !s1_b0_ff[0] && !halt_ff;
   assign fin_issue = s1_valid_ff && is_fin && !fin_wait_ff;
   assign exec_fire = s1_valid_ff && out_free && !(is_fin && !fin_wait_ff);
   assign req_tready = !clearing_ff && (!s1_valid_ff || exec_fire);
   assign accept     = req_tvalid && req_tready;

   // FIN reads pair 0 for its address; everything else reads the pair named by the operand
   assign rf_rd_addr = (req_tdata[7:4] == nibcpu_pkg::OP_FIN) ?
                       nibcpu_pkg::PAIR_AW'(0) : req_tdata[3:1];

   always_comb begin
      opr      = s1_b0_ff[7:4];
      opa      = s1_b0_ff[3:0];
      reg_val  = opa[0] ? rf_rd_data[3:0] : rf_rd_data[7:4];
      sum5     = {1'b0, acc_ff} + {1'b0, reg_val} + {4'b0000, carry_ff};
      sub_t    = {1'b0, reg_val} + {4'b0000, carry_ff};
      reg_inc  = reg_val + 4'd1;
      pc_inc1  = pc_ff + 12'd1;
      pc_inc2  = pc_ff + 12'd2;
      sel20    = {1'b0, chip_ff, 4'b0000} + {3'b000, chip_ff, 2'b00};
      st_addr9 = sel20 + {5'b00000, nib_ff};

      acc_in     = acc_ff;
      carry_in   = carry_ff;
      pc_in      = pc_ff;
      chip_in    = chip_ff;
      nib_in     = nib_ff;
      halt_in    = halt_ff;
      ex_rf_we   = 1'b0;
      ex_rf_data = rf_rd_data;
      ex_st_we   = 1'b0;

      if (!halt_ff) begin
         pc_in = pc_inc1;
         case (opr)
            nibcpu_pkg::OP_LDM: begin
               acc_in = opa;
            end
            nibcpu_pkg::OP_FIM_SRC: begin
               if (!opa[0]) begin
                  ex_rf_we   = 1'b1;
                  ex_rf_data = s1_b1_ff;
                  pc_in      = pc_inc2;
               end else begin
                  chip_in = rf_rd_data[7:4];
                  nib_in  = rf_rd_data[3:0];
               end
            end
            nibcpu_pkg::OP_FIN: begin
               if (!opa[0]) begin
                  ex_rf_we   = 1'b1;
                  ex_rf_data = {4'h0, st_rd_data};
               end
            end
            nibcpu_pkg::OP_LD: begin
               acc_in = reg_val;
            end
            nibcpu_pkg::OP_ADD: begin
               acc_in   = sum5[3:0];
               carry_in = sum5[4];
            end
            nibcpu_pkg::OP_SUB: begin
               carry_in = ({1'b0, acc_ff} >= sub_t);
               acc_in   = acc_ff - sub_t[3:0];
            end
            nibcpu_pkg::OP_XCH: begin
               acc_in     = reg_val;
               ex_rf_we   = 1'b1;
               ex_rf_data = opa[0] ? {rf_rd_data[7:4], acc_ff} : {acc_ff, rf_rd_data[3:0]};
            end
            nibcpu_pkg::OP_INC: begin
               ex_rf_we   = 1'b1;
               ex_rf_data = opa[0] ? {rf_rd_data[7:4], reg_inc} : {reg_inc, rf_rd_data[3:0]};
            end
            nibcpu_pkg::OP_ISZ: begin
               ex_rf_we   = 1'b1;
               ex_rf_data = opa[0] ? {rf_rd_data[7:4], reg_inc} : {reg_inc, rf_rd_data[3:0]};
               pc_in      = (reg_inc != 4'h0) ? {pc_inc2[11:8], s1_b1_ff} : pc_inc2;
            end
            nibcpu_pkg::OP_JUN: begin
               pc_in = {opa, s1_b1_ff};
            end
            nibcpu_pkg::OP_ACC: begin
               if (opa == nibcpu_pkg::OPA_CLB) begin
                  acc_in   = 4'h0;
                  carry_in = 1'b0;
               end else if (opa == nibcpu_pkg::OPA_IAC) begin
                  acc_in   = acc_ff + 4'd1;
                  carry_in = (acc_ff == 4'hF);
               end else if (opa == nibcpu_pkg::OPA_KBP) begin
                  halt_in = 1'b1;
               end
            end
            nibcpu_pkg::OP_IO: begin
               if (opa == nibcpu_pkg::OPA_WRM) begin
                  ex_st_we = 1'b1;
               end else if (opa[3:2] == nibcpu_pkg::OPA_WRN_GROUP) begin
                  ex_st_we = 1'b1;
                  st_addr9 = sel20 + 9'd16 + {7'b0000000, opa[1:0]};
               end
            end
            default: begin
            end
         endcase
      end
   end

   // clearing sweep owns both write ports until it ends
   always_comb begin
      if (clearing_ff) begin
         rf_wr.en   = (clr_cnt_ff < AW'(nibcpu_pkg::NUM_PAIRS));
         rf_wr.addr = clr_cnt_ff[nibcpu_pkg::PAIR_AW-1:0];
         rf_wr.data = 8'h00;
         st_wr_en   = 1'b1;
         st_wr_addr = clr_cnt_ff;
         st_wr_data = 4'h0;
      end else begin
         rf_wr.en   = exec_fire && ex_rf_we;
         rf_wr.addr = opa[3:1];
         rf_wr.data = ex_rf_data;
         st_wr_en   = exec_fire && ex_st_we;
         st_wr_addr = AW'(st_addr9);
         st_wr_data = acc_ff;
      end
   end

   nibcpu_regfile u_regfile (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rf_rd_addr),
      .rd_data (rf_rd_data),
      .wr      (rf_wr)
   );

   nibcpu_store #(
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (fin_issue),
      .rd_addr (AW'(rf_rd_data)),
      .rd_data (st_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fin_wait_ff  <= 1'b0;
         acc_ff       <= 4'h0;
         carry_ff     <= 1'b0;
         pc_ff        <= 12'h000;
         chip_ff      <= 4'h0;
         nib_ff       <= 4'h0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(STORE_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end

         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            s1_valid_ff <= 1'b0;
         end

         if (fin_issue) begin
            fin_wait_ff <= 1'b1;
         end else if (exec_fire) begin
            fin_wait_ff <= 1'b0;
         end

         if (exec_fire) begin
            acc_ff   <= acc_in;
            carry_ff <= carry_in;
            pc_ff    <= pc_in;
            chip_ff  <= chip_in;
            nib_ff   <= nib_in;
            halt_ff  <= halt_in;
         end

         // hold the result until the transfer completes
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_b0_ff <= req_tdata[7:0];
         s1_b1_ff <= req_tdata[15:8];
      end
      if (exec_fire) begin
         rsp_data_ff <= {6'b000000, halt_in, carry_in, acc_in, pc_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared after KBP");

   a_halted_pc_frozen: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && exec_fire) |=> $stable(pc_ff) && $stable(acc_ff))
      else $error("state changed while halted");

   a_fin_wait_has_item: assert property (@(posedge clock) disable iff (reset)
      fin_wait_ff |-> s1_valid_ff && is_fin)
      else $error("FIN wait without a FIN in execute");

   a_no_take_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !accept && !rsp_valid_ff)
      else $error("item taken during clearing sweep");
`endif

endmodule

### hdl/nibcpu_regfile.sv
`timescale 1ns / 1ps
// Index register file: eight 8-bit register pairs, one write and one registered read port.
// Read data forwards a same-cycle write to the same pair. Depends on nibcpu_pkg.
module nibcpu_regfile (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [nibcpu_pkg::PAIR_AW-1:0] rd_addr,
   output logic [7:0]                   rd_data,
   input  nibcpu_pkg::rf_wr_type        wr
);

   logic [7:0] mem [nibcpu_pkg::NUM_PAIRS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         // forward the pair being written so back-to-back items see it
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/nibcpu_store.sv
`timescale 1ns / 1ps
// Data nibble store: single-port-write, single-port-read RAM with registered read data.
// Standalone; sized by the DEPTH parameter from the top level.
module nibcpu_store #(
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [3:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [3:0]    rd_data
);

   logic [3:0] mem [DEPTH];
   logic [3:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for nibble_cpu_instruction_step: directed table, then random programs.
// Needs nibcpu_pkg and the block's RTL; prediction runs in the bench itself.
module tb;

   localparam int STORE_DEPTH = 512;
   localparam int N_DIRECTED  = 29;
   localparam int N_ITEMS     = 1400;
   localparam int CYCLE_LIMIT = 600000;

   // Opcodes outside the supported subset
   localparam logic [3:0] OP_NOP = 4'h0;
   localparam logic [3:0] OP_JMS = 4'h5;
   localparam logic [3:0] OP_BBL = 4'hC;

   typedef struct packed {
      logic [5:0]  zero;
      logic        halted;
      logic        carry;
      logic [3:0]  acc;
      logic [11:0] pc;
   } cpu_view_type;

   typedef struct packed {
      logic [7:0]   op_byte;
      logic [7:0]   next_byte;
      logic         typed;
      cpu_view_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] first_byte, [15:8] second_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [11:0] next_pc, [15:12] accumulator,
                                  // [16] carry_flag, [17] halted, [23:18] zero

   int cycle_count = 0;
   int error_count = 0;
   int item_count  = 0;
   int stall_left  = 0;

   // Shadow machine state
   logic [3:0]  regs [16];
   logic [3:0]  acc_q;
   logic        carry_q;
   logic [11:0] pc_q;
   logic [3:0]  chip_q;
   logic [3:0]  nib_q;
   logic [3:0]  mem [STORE_DEPTH];
   logic        stopped;

   cpu_view_type pending_states [$];
   dir_row_type  dir_rows [N_DIRECTED];

   nibble_cpu_instruction_step #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("nibble_cpu_instruction_step verification failed");
         $finish;
      end
   end

   function automatic cpu_view_type view(input logic [11:0] pc, input logic [3:0] acc,
                                         input logic c, input logic h);
      return '{zero: 6'd0, halted: h, carry: c, acc: acc, pc: pc};
   endfunction

   // Execute one instruction on the shadow state and return what the block should report
   function automatic cpu_view_type execute_instr(input logic [7:0] op_byte,
                                                  input logic [7:0] next_byte);
      logic [3:0]  opr;
      logic [3:0]  opa;
      logic [11:0] npc;
      logic [4:0]  sum;
      logic [3:0]  tmp;
      int          pr;
      int          addr;
      opr = op_byte[7:4];
      opa = op_byte[3:0];
      npc = pc_q + 12'd1;
      pr  = int'({opa[3:1], 1'b0});
      if (!stopped) begin
         case (opr)
            nibcpu_pkg::OP_LDM: acc_q = opa;
            nibcpu_pkg::OP_FIM_SRC: begin
               if (!opa[0]) begin
                  regs[pr]     = next_byte[7:4];
                  regs[pr + 1] = next_byte[3:0];
                  npc = pc_q + 12'd2;
               end else begin
                  chip_q = regs[pr];
                  nib_q  = regs[pr + 1];
               end
            end
            nibcpu_pkg::OP_FIN: begin
               if (!opa[0]) begin
                  // read before the pair is overwritten; the pair may be P0
                  addr = int'({regs[0], regs[1]}) % STORE_DEPTH;
                  tmp  = mem[addr];
                  regs[pr]     = 4'd0;
                  regs[pr + 1] = tmp;
               end
            end
            nibcpu_pkg::OP_LD: acc_q = regs[opa];
            nibcpu_pkg::OP_ADD: begin
               sum = {1'b0, acc_q} + {1'b0, regs[opa]} + {4'd0, carry_q};
               acc_q   = sum[3:0];
               carry_q = sum[4];
            end
            nibcpu_pkg::OP_SUB: begin
               sum = {1'b0, regs[opa]} + {4'd0, carry_q};
               carry_q = ({1'b0, acc_q} >= sum);
               acc_q   = acc_q - sum[3:0];
            end
            nibcpu_pkg::OP_XCH: begin
               tmp = acc_q;
               acc_q = regs[opa];
               regs[opa] = tmp;
            end
            nibcpu_pkg::OP_INC: regs[opa] = regs[opa] + 4'd1;
            nibcpu_pkg::OP_ISZ: begin
               regs[opa] = regs[opa] + 4'd1;
               npc = pc_q + 12'd2;
               if (regs[opa] != 4'd0) npc = {npc[11:8], next_byte};
            end
            nibcpu_pkg::OP_JUN: npc = {opa, next_byte};
            nibcpu_pkg::OP_ACC: begin
               if (opa == nibcpu_pkg::OPA_CLB) begin
                  acc_q   = 4'd0;
                  carry_q = 1'b0;
               end else if (opa == nibcpu_pkg::OPA_IAC) begin
                  sum = {1'b0, acc_q} + 5'd1;
                  acc_q   = sum[3:0];
                  carry_q = sum[4];
               end else if (opa == nibcpu_pkg::OPA_KBP) begin
                  stopped = 1'b1;
               end
            end
            nibcpu_pkg::OP_IO: begin
               if (opa == nibcpu_pkg::OPA_WRM) begin
                  addr = (int'(chip_q) * 20 + int'(nib_q)) % STORE_DEPTH;
                  mem[addr] = acc_q;
               end else if (opa[3:2] == nibcpu_pkg::OPA_WRN_GROUP) begin
                  addr = (int'(chip_q) * 20 + 16 + int'(opa[1:0])) % STORE_DEPTH;
                  mem[addr] = acc_q;
               end
            end
            default: ;
         endcase
         pc_q = npc;
      end
      return view(pc_q, acc_q, carry_q, stopped);
   endfunction

   // Mostly short gaps, a few long ones; none during calm windows
   function automatic int pick_gap();
      int r;
      if ((cycle_count / 256) % 4 == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_mismatch(input string what, input logic [23:0] got,
                                input logic [23:0] want);
      error_count++;
      if (error_count <= 50)
         $display("ERROR cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
   endtask

   task automatic check_result(input cpu_view_type got);
      cpu_view_type want;
      if (pending_states.size() == 0) begin
         flag_mismatch("result with nothing pending", got, '0);
      end else begin
         want = pending_states.pop_front();
         if (got.pc !== want.pc)
            flag_mismatch("next_pc", 24'(got.pc), 24'(want.pc));
         if (got.acc !== want.acc)
            flag_mismatch("accumulator", 24'(got.acc), 24'(want.acc));
         if (got.carry !== want.carry)
            flag_mismatch("carry_flag", 24'(got.carry), 24'(want.carry));
         if (got.halted !== want.halted)
            flag_mismatch("halted", 24'(got.halted), 24'(want.halted));
         if (got.zero !== want.zero)
            flag_mismatch("pad bits", 24'(got.zero), 24'(want.zero));
      end
   endtask

   // Offer one instruction and hold it until the transfer happens
   task automatic issue(input logic [7:0] op_byte, input logic [7:0] next_byte,
                        input logic typed, input cpu_view_type want);
      int           gap;
      cpu_view_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {next_byte, op_byte};
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = execute_instr(op_byte, next_byte);
      pending_states.push_back(typed ? want : pred);
      item_count++;
   endtask

   task automatic send(input logic [7:0] op_byte, input logic [7:0] next_byte);
      issue(op_byte, next_byte, 1'b0, '0);
   endtask

   // Select an address with SRC, write a nibble through WRM or WRN and read it back through FIN
   task automatic store_roundtrip();
      logic [2:0] p;
      logic [2:0] q;
      logic [1:0] k;
      logic [3:0] chip;
      logic [3:0] nib;
      logic       status;
      int         addr;
      p      = 3'($urandom_range(0, 7));
      q      = 3'($urandom_range(0, 7));
      k      = 2'($urandom_range(0, 3));
      chip   = 4'($urandom_range(0, 11));
      nib    = 4'($urandom_range(0, 15));
      status = 1'($urandom_range(0, 1));
      addr   = status ? int'(chip) * 20 + 16 + int'(k) : int'(chip) * 20 + int'(nib);
      send({nibcpu_pkg::OP_FIM_SRC, p, 1'b0}, {chip, nib});
      send({nibcpu_pkg::OP_FIM_SRC, p, 1'b1}, 8'($urandom));
      send({nibcpu_pkg::OP_LDM, 4'($urandom_range(0, 15))}, 8'($urandom));
      send({nibcpu_pkg::OP_IO,
            status ? {nibcpu_pkg::OPA_WRN_GROUP, k} : nibcpu_pkg::OPA_WRM}, 8'($urandom));
      send({nibcpu_pkg::OP_FIM_SRC, 4'd0}, 8'(addr));
      send({nibcpu_pkg::OP_FIN, q, 1'b0}, 8'($urandom));
      send({nibcpu_pkg::OP_LD, q, 1'b1}, 8'($urandom));
   endtask

   function automatic logic [7:0] random_instr();
      int r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 10)      b = {nibcpu_pkg::OP_LDM, 4'($urandom_range(0, 15))};
      else if (r < 20) b = {nibcpu_pkg::OP_FIM_SRC, 3'($urandom_range(0, 7)), 1'b0};
      else if (r < 28) b = {nibcpu_pkg::OP_FIM_SRC, 3'($urandom_range(0, 7)), 1'b1};
      else if (r < 36) b = {nibcpu_pkg::OP_FIN, 3'($urandom_range(0, 7)), 1'b0};
      else if (r < 42) b = {nibcpu_pkg::OP_LD, 4'($urandom_range(0, 15))};
      else if (r < 52) b = {nibcpu_pkg::OP_ADD, 4'($urandom_range(0, 15))};
      else if (r < 60) b = {nibcpu_pkg::OP_SUB, 4'($urandom_range(0, 15))};
      else if (r < 65) b = {nibcpu_pkg::OP_XCH, 4'($urandom_range(0, 15))};
      else if (r < 70) b = {nibcpu_pkg::OP_INC, 4'($urandom_range(0, 15))};
      else if (r < 76) b = {nibcpu_pkg::OP_ISZ, 4'($urandom_range(0, 15))};
      else if (r < 80) b = {nibcpu_pkg::OP_JUN, 4'($urandom_range(0, 15))};
      else if (r < 84) b = {nibcpu_pkg::OP_ACC, ($urandom_range(0, 1) != 0) ?
                            nibcpu_pkg::OPA_IAC : nibcpu_pkg::OPA_CLB};
      else if (r < 88) b = {nibcpu_pkg::OP_IO, nibcpu_pkg::OPA_WRM};
      else if (r < 94) b = {nibcpu_pkg::OP_IO, nibcpu_pkg::OPA_WRN_GROUP,
                            2'($urandom_range(0, 3))};
      else             b = 8'($urandom);
      // keep the machine running until the final stretch
      if (b == {nibcpu_pkg::OP_ACC, nibcpu_pkg::OPA_KBP})
         b = {nibcpu_pkg::OP_ACC, nibcpu_pkg::OPA_IAC};
      return b;
   endfunction

   initial begin
      int i;
      cpu_view_type got_view;
      for (i = 0; i < 16; i++) regs[i] = 4'd0;
      for (i = 0; i < STORE_DEPTH; i++) mem[i] = 4'd0;
      acc_q   = 4'd0;
      carry_q = 1'b0;
      pc_q    = 12'd0;
      chip_q  = 4'd0;
      nib_q   = 4'd0;
      stopped = 1'b0;
      got_view = '0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            got_view = cpu_view_type'(rsp_tdata);
            check_result(got_view);
         end
         if (stall_left == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int d;
      dir_rows = '{
         '{{nibcpu_pkg::OP_LDM, 4'hF},     8'h00, 1'b1, view(12'h001, 4'hF, 1'b0, 1'b0)},
         '{{nibcpu_pkg::OP_FIM_SRC, 4'h0}, 8'hFF, 1'b1, view(12'h003, 4'hF, 1'b0, 1'b0)},
         '{{nibcpu_pkg::OP_FIM_SRC, 4'hE}, 8'h5A, 1'b0, '0},
         '{{nibcpu_pkg::OP_JUN, 4'hF},     8'hFF, 1'b1, view(12'hFFF, 4'hF, 1'b0, 1'b0)},
         '{{nibcpu_pkg::OP_LDM, 4'h9},     8'hFF, 1'b1, view(12'h000, 4'h9, 1'b0, 1'b0)},
         '{{nibcpu_pkg::OP_ADD, 4'h0},     8'h00, 1'b1, view(12'h001, 4'h8, 1'b1, 1'b0)},
         '{{nibcpu_pkg::OP_SUB, 4'hE},     8'hA5, 1'b0, '0},
         '{{nibcpu_pkg::OP_LDM, 4'hF},     8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_ACC, nibcpu_pkg::OPA_IAC}, 8'h00, 1'b1,
           view(12'h004, 4'h0, 1'b1, 1'b0)},
         '{{nibcpu_pkg::OP_ACC, nibcpu_pkg::OPA_CLB}, 8'hFF, 1'b1,
           view(12'h005, 4'h0, 1'b0, 1'b0)},
         '{{nibcpu_pkg::OP_SUB, 4'hF},     8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_XCH, 4'h3},     8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_INC, 4'h1},     8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_ISZ, 4'h0},     8'h34, 1'b0, '0},
         '{{nibcpu_pkg::OP_ISZ, 4'hE},     8'h80, 1'b0, '0},
         '{{nibcpu_pkg::OP_FIM_SRC, 4'hF}, 8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_LDM, 4'hC},     8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_IO, nibcpu_pkg::OPA_WRM}, 8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_IO, nibcpu_pkg::OPA_WRN_GROUP, 2'd3}, 8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_FIM_SRC, 4'h0}, 8'h82, 1'b0, '0},
         '{{nibcpu_pkg::OP_FIN, 4'h4},     8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_LD, 4'h5},      8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_LD, 4'hF},      8'h00, 1'b0, '0},
         '{{OP_NOP, 4'h0},                 8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_FIN, 4'h1},     8'hFF, 1'b0, '0},
         '{{OP_JMS, 4'hA},                 8'h12, 1'b0, '0},
         '{{OP_BBL, 4'h3},                 8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_IO, 4'h1},      8'h00, 1'b0, '0},
         '{{nibcpu_pkg::OP_ACC, 4'hF},     8'hFF, 1'b0, '0}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (d = 0; d < N_DIRECTED; d++)
         issue(dir_rows[d].op_byte, dir_rows[d].next_byte, dir_rows[d].typed,
               dir_rows[d].want);
      while (item_count < N_ITEMS) begin
         if ($urandom_range(0, 99) < 12) store_roundtrip();
         else send(random_instr(), 8'($urandom));
      end
      // halt, then confirm that later instructions leave the state alone
      send({nibcpu_pkg::OP_ACC, nibcpu_pkg::OPA_KBP}, 8'($urandom));
      for (d = 0; d < 4; d++) send(8'($urandom), 8'($urandom));
      req_tvalid <= 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("nibble_cpu_instruction_step verification clean");
      end else begin
         $display("nibble_cpu_instruction_step verification failed");
      end
      $finish;
   end

endmodule
